[rtl/core/pcp_pkg.sv]
// Shared types, widths and register codes for the periodic contact penalty block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package pcp_pkg;

    // Field and datapath widths.
    localparam int COORD_W = 24;
    localparam int FRAC_W  = 20;
    localparam int ROT_W   = 18;
    localparam int LIM_W   = 20;
    localparam int WGT_W   = 16;
    localparam int WSQ_W   = 48;
    localparam int ROW_W   = 63;
    localparam int MAT_W   = 21;
    localparam int D_W     = 27;
    localparam int F_W     = 21;
    localparam int PROD_W  = 42;
    localparam int P_W     = 46;
    localparam int Q_W     = 30;
    localparam int AQ_W    = 28;
    localparam int SQ_W    = 56;
    localparam int S_W     = 58;
    localparam int RAD_W   = 50;
    localparam int ROOT_W  = 25;
    localparam int CAND_W  = RAD_W + 2;
    localparam int NSHIFT  = 27;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORTH_ROW_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORTH_ROW_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORTH_ROW_2 = 2'd2;

    // Rotation entry codes; the remaining code reads as zero.
    localparam logic [1:0] ROT_ZERO = 2'b00;
    localparam logic [1:0] ROT_POS  = 2'b01;
    localparam logic [1:0] ROT_NEG  = 2'b11;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [D_W-1:0]     t_diff;
    typedef logic signed [F_W-1:0]     t_frac;
    typedef logic signed [MAT_W-1:0]   t_mat;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [P_W-1:0]     t_pmat;
    typedef logic signed [Q_W-1:0]     t_q;
    typedef logic [ROW_W-1:0]          t_row;

    // Side data that rides along with every item.
    typedef struct packed {
        logic [LIM_W-1:0] limit;
        logic [WGT_W-1:0] weight;
    } t_side;

endpackage

`default_nettype wire

[rtl/core/pcp_front.sv]
// Front end: symmetry mapping of atom B and nearest-integer cell reduction.
// Depends on pcp_pkg.
`default_nettype none

module pcp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  pcp_pkg::t_coord    i_a [3],
    input  pcp_pkg::t_coord    i_b [3],
    input  pcp_pkg::t_coord    i_t [3],
    input  logic [pcp_pkg::ROT_W-1:0] i_rot,
    input  pcp_pkg::t_side     i_side,
    output logic               o_valid,
    output pcp_pkg::t_frac     o_f [3],
    output pcp_pkg::t_side     o_side
);
    import pcp_pkg::*;

    // One rotation entry times a coordinate.
    function automatic t_diff rot_term(input logic [1:0] code, input t_coord b);
        case (code)
            ROT_POS: rot_term = t_diff'(b);
            ROT_NEG: rot_term = -t_diff'(b);
            default: rot_term = '0;
        endcase
    endfunction

    logic [1:0]  r_v;
    t_diff       n_d [3];
    t_diff       r_d [3];
    t_frac       n_f [3];
    t_frac       r_f [3];
    t_side       r_side [2];
    logic [D_W-1:0] mag [3];
    logic [6:0]     rnd [3];
    logic signed [D_W:0] fa [3];

    // Stage 1: d = A - (R*B + t).
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = t_diff'(i_a[i]) - t_diff'(i_t[i]);
            for (int j = 0; j < 3; j++) begin
                n_d[i] = n_d[i] - rot_term(i_rot[2*(3*i+j) +: 2], i_b[j]);
            end
        end
    end

    // Stage 2: subtract the nearest integer, halves away from zero.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = r_d[i][D_W-1] ? D_W'(-r_d[i]) : D_W'(r_d[i]);
            rnd[i] = 7'((mag[i] + D_W'(1 << (FRAC_W - 1))) >> FRAC_W);
            fa[i]  = $signed({1'b0, mag[i]}) - $signed({1'b0, rnd[i], {FRAC_W{1'b0}}});
            n_f[i] = r_d[i][D_W-1] ? t_frac'(-fa[i]) : t_frac'(fa[i]);
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d       <= n_d;
            r_f       <= n_f;
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
        end
    end

    assign o_valid = r_v[1];
    assign o_f     = r_f;
    assign o_side  = r_side[1];

endmodule

`default_nettype wire

[rtl/core/pcp_image.sv]
// Minimum image search: orthogonalization, 27 neighbor shifts, squared lengths
// and a registered minimum tree. Depends on pcp_pkg.
`default_nettype none

module pcp_image (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  pcp_pkg::t_frac  i_f [3],
    input  pcp_pkg::t_row   i_rows [3],
    input  pcp_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [pcp_pkg::S_W-1:0] o_best,
    output pcp_pkg::t_side  o_side
);
    import pcp_pkg::*;

    localparam int NSTG = 8;

    // Contribution of one whole cell step along a column of the matrix.
    function automatic t_pmat shift_term(input int s, input t_mat m);
        t_pmat c;
        c = t_pmat'(m) <<< FRAC_W;
        if (s == 0) begin
            shift_term = -c;
        end else if (s == 2) begin
            shift_term = c;
        end else begin
            shift_term = '0;
        end
    endfunction

    function automatic logic [S_W-1:0] min3(input logic [S_W-1:0] a,
                                           input logic [S_W-1:0] b,
                                           input logic [S_W-1:0] c);
        logic [S_W-1:0] m;
        m = (b < a) ? b : a;
        min3 = (c < m) ? c : m;
    endfunction

    logic [NSTG-1:0] r_v;
    t_side           r_side [NSTG];
    t_mat            m [3][3];
    t_prod           r_prod [3][3];
    t_pmat           r_p [3];
    t_pmat           pv [NSHIFT][3];
    t_q              r_q [NSHIFT][3];
    logic [AQ_W-1:0] aq [NSHIFT][3];
    logic [SQ_W-1:0] r_sq [NSHIFT][3];
    logic [S_W-1:0]  r_s [NSHIFT];
    logic [S_W-1:0]  r_m1 [9];
    logic [S_W-1:0]  r_m2 [3];
    logic [S_W-1:0]  r_best;

    // Matrix entries from the row registers.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m[i][j] = $signed(i_rows[i][MAT_W*j +: MAT_W]);
            end
        end
    end

    // Shifted vectors through the matrix, rounded to Q.16.
    always_comb begin
        for (int ix = 0; ix < 3; ix++) begin
            for (int iy = 0; iy < 3; iy++) begin
                for (int iz = 0; iz < 3; iz++) begin
                    for (int i = 0; i < 3; i++) begin
                        pv[9*ix+3*iy+iz][i] = r_p[i] + shift_term(ix, m[i][0])
                            + shift_term(iy, m[i][1]) + shift_term(iz, m[i][2]);
                    end
                end
            end
        end
    end

    // Magnitudes of the rounded components.
    always_comb begin
        for (int n = 0; n < NSHIFT; n++) begin
            for (int i = 0; i < 3; i++) begin
                aq[n][i] = r_q[n][i][Q_W-1] ? AQ_W'(-r_q[n][i]) : AQ_W'(r_q[n][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    // Datapath stages: products, row sums, shifts, squares, lengths, min tree.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= t_prod'(m[i][j] * i_f[j]);
                end
                r_p[i] <= t_pmat'(r_prod[i][0]) + t_pmat'(r_prod[i][1])
                        + t_pmat'(r_prod[i][2]);
            end
            for (int n = 0; n < NSHIFT; n++) begin
                for (int i = 0; i < 3; i++) begin
                    r_q[n][i]  <= t_q'((pv[n][i] + t_pmat'(32768)) >>> 16);
                    r_sq[n][i] <= SQ_W'(aq[n][i] * aq[n][i]);
                end
                r_s[n] <= S_W'(r_sq[n][0]) + S_W'(r_sq[n][1]) + S_W'(r_sq[n][2]);
            end
            for (int k = 0; k < 9; k++) begin
                r_m1[k] <= min3(r_s[3*k], r_s[3*k+1], r_s[3*k+2]);
            end
            for (int k = 0; k < 3; k++) begin
                r_m2[k] <= min3(r_m1[3*k], r_m1[3*k+1], r_m1[3*k+2]);
            end
            r_best    <= min3(r_m2[0], r_m2[1], r_m2[2]);
            r_side[0] <= i_side;
            for (int k = 1; k < NSTG; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_best  = r_best;
    assign o_side  = r_side[NSTG-1];

endmodule

`default_nettype wire

[rtl/core/pcp_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on pcp_pkg.
`default_nettype none

module pcp_isqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [pcp_pkg::RAD_W-1:0] i_x,
    input  pcp_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [pcp_pkg::ROOT_W-1:0] o_root,
    output pcp_pkg::t_side  o_side
);
    import pcp_pkg::*;

    logic [ROOT_W-1:0] r_v;
    logic [ROOT_W-1:0] s_root [ROOT_W+1];
    logic [RAD_W-1:0]  s_sq   [ROOT_W+1];
    logic [RAD_W-1:0]  s_x    [ROOT_W+1];
    t_side             s_side [ROOT_W+1];

    assign s_root[0] = '0;
    assign s_sq[0]   = '0;
    assign s_x[0]    = i_x;
    assign s_side[0] = i_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ROOT_W-2:0], i_valid};
        end
    end

    // Each stage tries the next lower root bit, tracking root squared.
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int B = ROOT_W - 1 - k;
        logic [CAND_W-1:0] cand;
        logic              take;
        logic [ROOT_W-1:0] r_root;
        logic [RAD_W-1:0]  r_sq;
        logic [RAD_W-1:0]  r_x;
        t_side             r_side;

        assign cand = CAND_W'(s_sq[k]) + (CAND_W'(s_root[k]) << (B + 1))
                    + (CAND_W'(1) << (2 * B));
        assign take = cand <= CAND_W'(s_x[k]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root <= take ? (s_root[k] | (ROOT_W'(1) << B)) : s_root[k];
                r_sq   <= take ? RAD_W'(cand) : s_sq[k];
                r_x    <= s_x[k];
                r_side <= s_side[k];
            end
        end

        assign s_root[k+1] = r_root;
        assign s_sq[k+1]   = r_sq;
        assign s_x[k+1]    = r_x;
        assign s_side[k+1] = r_side;
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = s_root[ROOT_W];
    assign o_side  = s_side[ROOT_W];

endmodule

`default_nettype wire

[rtl/core/periodic_contact_penalty.sv]
// Top level of the periodic contact penalty pipeline with its matrix registers.
// Depends on pcp_pkg, pcp_front, pcp_image and pcp_isqrt.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | i_valid / o_stall      | atoms A, B, rotation, shift, limit, weight
//  output   | o_valid / i_stall      | penalty, weighted square
//  config   | i_cfg_valid / o_cfg_ready | register index, 63-bit row
//
// One item enters per cycle while o_stall is low; the stages are 2 front, 8 image search,
// 25 square root (one root bit per stage) and 3 penalty stages.
// The whole pipeline advances together; it halts only when a result waits
// at the output while i_stall is high, and then o_stall is raised.
// Synchronous active-low reset clears valid bits and the matrix rows.
`default_nettype none

module periodic_contact_penalty (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [23:0] i_a_x,
    input  logic signed [23:0] i_a_y,
    input  logic signed [23:0] i_a_z,
    input  logic signed [23:0] i_b_x,
    input  logic signed [23:0] i_b_y,
    input  logic signed [23:0] i_b_z,
    input  logic [17:0] i_rot_code,
    input  logic signed [23:0] i_shift_x,
    input  logic signed [23:0] i_shift_y,
    input  logic signed [23:0] i_shift_z,
    input  logic [19:0] i_min_distance,
    input  logic [15:0] i_weight,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [19:0] o_penalty,
    output logic [47:0] o_weighted_square,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcp_pkg::ROW_W-1:0]     i_cfg_data
);
    import pcp_pkg::*;

    logic         en;
    t_row         r_orth [3];
    t_coord       s_a [3];
    t_coord       s_b [3];
    t_coord       s_t [3];
    t_side        s_side_in;
    logic         fr_valid;
    t_frac        fr_f [3];
    t_side        fr_side;
    logic         im_valid;
    logic [S_W-1:0] im_best;
    t_side        im_side;
    logic         sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_side        sq_side;
    logic         r_pv;
    logic [LIM_W-1:0] r_pen;
    logic [WGT_W-1:0] r_pw;
    logic         r_qv;
    logic [2*LIM_W-1:0] r_pen2;
    logic [LIM_W-1:0] r_qpen;
    logic [WGT_W-1:0] r_qw;
    logic         r_out_v;
    logic [LIM_W-1:0] r_out_pen;
    logic [WSQ_W-1:0] r_out_wsq;
    logic [2*LIM_W+WGT_W-1:0] wprod;

    // Global advance: hold everything while a result waits to be taken.
    assign en      = !(r_out_v && i_stall);
    assign o_stall = !en;

    // Matrix row registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orth[0] <= '0;
            r_orth[1] <= '0;
            r_orth[2] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORTH_ROW_0: r_orth[0] <= i_cfg_data;
                CFG_ORTH_ROW_1: r_orth[1] <= i_cfg_data;
                CFG_ORTH_ROW_2: r_orth[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_a = '{i_a_x, i_a_y, i_a_z};
    assign s_b = '{i_b_x, i_b_y, i_b_z};
    assign s_t = '{i_shift_x, i_shift_y, i_shift_z};
    assign s_side_in.limit  = i_min_distance;
    assign s_side_in.weight = i_weight;

    pcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (s_a),
        .i_b     (s_b),
        .i_t     (s_t),
        .i_rot   (i_rot_code),
        .i_side  (s_side_in),
        .o_valid (fr_valid),
        .o_f     (fr_f),
        .o_side  (fr_side)
    );

    pcp_image u_image (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_f     (fr_f),
        .i_rows  (r_orth),
        .i_side  (fr_side),
        .o_valid (im_valid),
        .o_best  (im_best),
        .o_side  (im_side)
    );

    pcp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (im_valid),
        .i_x     (im_best[S_W-1:8]),
        .i_side  (im_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign wprod = r_pen2 * r_qw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_qv    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_pv    <= sq_valid;
            r_qv    <= r_pv;
            r_out_v <= r_qv;
        end
    end

    // Penalty, its square, then the weighted square into the output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pen     <= (ROOT_W'(sq_side.limit) > sq_root)
                       ? LIM_W'(ROOT_W'(sq_side.limit) - sq_root) : '0;
            r_pw      <= sq_side.weight;
            r_pen2    <= r_pen * r_pen;
            r_qpen    <= r_pen;
            r_qw      <= r_pw;
            r_out_pen <= r_qpen;
            r_out_wsq <= wprod[WSQ_W+7:8];
        end
    end

    assign o_valid           = r_out_v;
    assign o_penalty         = r_out_pen;
    assign o_weighted_square = r_out_wsq;

`ifndef NO_ASSERTIONS
    // A result held at the output must hold back the input side.
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input accepted while output result is stalled");

    // No penalty means no weighted cost.
    a_zero_pen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_penalty == '0) |-> (o_weighted_square == '0))
        else $error("weighted square nonzero with zero penalty");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled pipeline holds the penalty square register r_pen2 while r_qv is low.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !r_qv) |=> $stable(r_pen2))
        else $error("pipeline changed while halted");
`endif

endmodule

`default_nettype wire
